>>> sv/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants for the pattern replace block
// Word structs, configuration register codes, cell control structs.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;
  localparam int RES_MAX     = 8;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int CNT_W       = 4;
  localparam int REG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LEN   = 2'd0,
    REG_PATTERN_BYTES = 2'd1,
    REG_REPLACE_LEN   = 2'd2,
    REG_REPLACE_BYTES = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic step;   // word accepted with a nonempty pattern
    logic shift;  // full window missed, drop oldest byte
  } win_ctl_t;

  typedef struct packed {
    logic load;   // new burst from an accepted word
    logic pop;    // head word taken by the receiver
  } obuf_ctl_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] lim);
    logic [LEN_W-1:0] n;
    n = (v > LEN_W'(8)) ? LEN_W'(8) : v;
    if (n > lim) n = lim;
    return n;
  endfunction

endpackage

>>> sv/spr_win_cell.sv
// ----------------------------------------------------------------------------
// spr_win_cell: one byte of the match window
// Holds a window byte, compares it with its pattern byte, shifts to neighbor.
// ----------------------------------------------------------------------------
module spr_win_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spr_pkg::win_ctl_t         ctl_i,
  input  logic                      sel_i,      // this cell takes the new byte
  input  logic                      active_i,   // cell lies inside the pattern
  input  logic [spr_pkg::BYTE_W-1:0] new_byte_i,
  input  logic [spr_pkg::BYTE_W-1:0] pat_byte_i,
  input  logic [spr_pkg::BYTE_W-1:0] nb_byte_i,  // next cell's effective byte
  output logic [spr_pkg::BYTE_W-1:0] eff_byte_o,
  output logic                      eq_o
);

  logic [spr_pkg::BYTE_W-1:0] byte_q, byte_d;

  assign eff_byte_o = sel_i ? new_byte_i : byte_q;
  assign eq_o       = !active_i || (eff_byte_o == pat_byte_i);

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.step) begin
      if (ctl_i.shift) begin
        byte_d = nb_byte_i;
      end else if (sel_i) begin
        byte_d = new_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

>>> sv/spr_obuf_cell.sv
// ----------------------------------------------------------------------------
// spr_obuf_cell: one slot of the output burst queue
// Loads a result word in parallel, shifts toward the head on each pop.
// ----------------------------------------------------------------------------
module spr_obuf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spr_pkg::obuf_ctl_t ctl_i,
  input  spr_pkg::out_word_t ld_word_i,
  input  spr_pkg::out_word_t nb_word_i,
  output spr_pkg::out_word_t word_o
);

  spr_pkg::out_word_t word_q, word_d;

  assign word_o = word_q;

  always_comb begin
    word_d = word_q;
    if (ctl_i.load) begin
      word_d = ld_word_i;
    end else if (ctl_i.pop) begin
      word_d = nb_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

endmodule

>>> sv/stream_pattern_replace.sv
// ----------------------------------------------------------------------------
// stream_pattern_replace: streaming fixed pattern find and replace
// Byte stream in, rewritten byte stream out, leftmost non-overlapping matches.
// ----------------------------------------------------------------------------
// Input channel: one word per byte (data_byte, end_of_string), valid/ready.
// Output channel: words of (out_byte, byte_valid, last), valid/ready. A bare
// end mark (byte_valid = 0, last = 1) ends a string that yields no byte.
// Config: write pattern_len, pattern_bytes, replace_len, replace_bytes by
// index while idle; writing pattern_len empties the window.
// An accepted word is compared in the same cycle by a row of window cells
// and yields 0 to 8 result words, loaded into an 8-slot output queue.
// The first result appears in the cycle after acceptance. A word that
// yields 0 or 1 results sustains one word per cycle while out_ready_i is
// high; a burst holds input ready low until its last word is being taken.
// Ready depends on out_ready_i when the queue holds its last word.
// A stalled receiver holds the queue head; input waits until the queue
// drains. Reset empties window and queue and clears all config registers.
// ----------------------------------------------------------------------------
module stream_pattern_replace (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spr_pkg::REG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  spr_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output spr_pkg::out_word_t              out_word_o
);

  localparam int BW = spr_pkg::BYTE_W;

  logic [spr_pkg::LEN_W-1:0] pattern_len_q, replace_len_q;
  logic [spr_pkg::REG_W-1:0] pattern_bytes_q, replace_bytes_q;
  logic [spr_pkg::CNT_W-1:0] win_cnt_q, win_cnt_d;
  logic [spr_pkg::CNT_W-1:0] obuf_cnt_q, obuf_cnt_d;

  logic [spr_pkg::LEN_W-1:0] plen, rlen;
  logic [spr_pkg::CNT_W-1:0] wc, new_cnt, res_cnt, res_n;
  logic                      in_acc, out_acc, eos, full, hit, bare, pass;
  logic [BW-1:0]             in_byte;

  spr_pkg::win_ctl_t  win_ctl;
  spr_pkg::obuf_ctl_t obuf_ctl;

  logic [spr_pkg::PATTERN_MAX-1:0][BW-1:0] eff_byte;
  logic [spr_pkg::PATTERN_MAX-1:0]         eq;
  spr_pkg::out_word_t [spr_pkg::RES_MAX-1:0] ld_word, q_word;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign in_byte = in_word_i.data_byte;
  assign eos     = in_word_i.end_of_string;

  assign plen = spr_pkg::clamp_len(pattern_len_q, spr_pkg::LEN_W'(spr_pkg::PATTERN_MAX));
  assign rlen = spr_pkg::clamp_len(replace_len_q, spr_pkg::LEN_W'(spr_pkg::REPLACE_MAX));
  assign pass = (plen == '0);

  assign wc      = (win_cnt_q >= plen) ? '0 : win_cnt_q;
  assign new_cnt = wc + spr_pkg::CNT_W'(1);
  assign full    = !pass && (new_cnt == plen);
  assign hit     = full && (&eq);

  assign win_ctl.step  = in_acc && !pass;
  assign win_ctl.shift = full && !hit;

  // window cells
  for (genvar i = 0; i < spr_pkg::PATTERN_MAX; i++) begin : g_win
    logic [BW-1:0] nb;
    if (i == spr_pkg::PATTERN_MAX - 1) begin : g_end
      assign nb = eff_byte[i];
    end else begin : g_mid
      assign nb = eff_byte[i+1];
    end
    spr_win_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (win_ctl),
      .sel_i      (wc == spr_pkg::CNT_W'(i)),
      .active_i   (spr_pkg::LEN_W'(i) < plen),
      .new_byte_i (in_byte),
      .pat_byte_i (pattern_bytes_q[i*BW +: BW]),
      .nb_byte_i  (nb),
      .eff_byte_o (eff_byte[i]),
      .eq_o       (eq[i])
    );
  end

  // result count for this word
  always_comb begin
    if (pass) begin
      res_cnt = spr_pkg::CNT_W'(1);
    end else if (hit) begin
      res_cnt = spr_pkg::CNT_W'(rlen);
    end else if (eos) begin
      res_cnt = new_cnt;
    end else begin
      res_cnt = full ? spr_pkg::CNT_W'(1) : '0;
    end
  end

  assign bare  = eos && (res_cnt == '0);
  assign res_n = bare ? spr_pkg::CNT_W'(1) : res_cnt;

  always_comb begin
    for (int i = 0; i < spr_pkg::RES_MAX; i++) begin
      ld_word[i] = '0;
      if (bare) begin
        ld_word[i].last = (i == 0);
      end else begin
        if (pass) begin
          ld_word[i].out_byte = (i == 0) ? in_byte : '0;
        end else if (hit) begin
          ld_word[i].out_byte = replace_bytes_q[i*BW +: BW];
        end else begin
          ld_word[i].out_byte = eff_byte[i];
        end
        ld_word[i].byte_valid = 1'b1;
        ld_word[i].last = eos && (spr_pkg::CNT_W'(i) == res_n - spr_pkg::CNT_W'(1));
      end
    end
  end

  // output queue
  assign obuf_ctl.load = in_acc;
  assign obuf_ctl.pop  = out_acc;

  for (genvar i = 0; i < spr_pkg::RES_MAX; i++) begin : g_obuf
    spr_pkg::out_word_t nb;
    if (i == spr_pkg::RES_MAX - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = q_word[i+1];
    end
    spr_obuf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (obuf_ctl),
      .ld_word_i (ld_word[i]),
      .nb_word_i (nb),
      .word_o    (q_word[i])
    );
  end

  assign out_valid_o = (obuf_cnt_q != '0);
  assign out_word_o  = q_word[0];
  assign in_ready_o  = (obuf_cnt_q == '0) ||
                       ((obuf_cnt_q == spr_pkg::CNT_W'(1)) && out_ready_i);

  always_comb begin
    obuf_cnt_d = obuf_cnt_q;
    if (in_acc) begin
      obuf_cnt_d = res_n;
    end else if (out_acc) begin
      obuf_cnt_d = obuf_cnt_q - spr_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    win_cnt_d = win_cnt_q;
    if (cfg_we_i && (spr_pkg::cfg_reg_e'(cfg_idx_i) == spr_pkg::REG_PATTERN_LEN)) begin
      win_cnt_d = '0;
    end else if (in_acc && !pass) begin
      if (eos || hit) begin
        win_cnt_d = '0;
      end else if (full) begin
        win_cnt_d = plen - spr_pkg::CNT_W'(1);
      end else begin
        win_cnt_d = new_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_len_q   <= '0;
      pattern_bytes_q <= '0;
      replace_len_q   <= '0;
      replace_bytes_q <= '0;
      win_cnt_q       <= '0;
      obuf_cnt_q      <= '0;
    end else begin
      win_cnt_q  <= win_cnt_d;
      obuf_cnt_q <= obuf_cnt_d;
      if (cfg_we_i) begin
        case (spr_pkg::cfg_reg_e'(cfg_idx_i))
          spr_pkg::REG_PATTERN_LEN:   pattern_len_q   <= cfg_data_i[spr_pkg::LEN_W-1:0];
          spr_pkg::REG_PATTERN_BYTES: pattern_bytes_q <= cfg_data_i;
          spr_pkg::REG_REPLACE_LEN:   replace_len_q   <= cfg_data_i[spr_pkg::LEN_W-1:0];
          spr_pkg::REG_REPLACE_BYTES: replace_bytes_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule
